>>> sv/deep_sleep_entry_sequencer_top_assert.svh
// ----------------------------------------------------------------------------
// deep sleep entry sequencer assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef DEEP_SLEEP_ENTRY_SEQUENCER_TOP_ASSERT_SVH
`define DEEP_SLEEP_ENTRY_SEQUENCER_TOP_ASSERT_SVH

// same-cycle implication
`define DSES_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DSES_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/dses_pkg.sv
// ----------------------------------------------------------------------------
// dses_pkg
// state and action codes, transition table and result record
// ----------------------------------------------------------------------------
package dses_pkg;

    typedef enum logic [3:0] {
        ST_ACTIVE    = 4'd0,
        ST_SLEEP_REQ = 4'd1,
        ST_DRAINING  = 4'd2,
        ST_LOGFLUSH  = 4'd3,
        ST_PORTS     = 4'd4,
        ST_RETAINED  = 4'd5,
        ST_ENTERING  = 4'd6,
        ST_WAKEBOOT  = 4'd7,
        ST_REJECTED  = 4'd8,
        ST_FAILED    = 4'd9
    } state_t;

    localparam logic [3:0] ACT_REQUEST_SLEEP   = 4'd0;
    localparam logic [3:0] ACT_DRAIN_DONE      = 4'd1;
    localparam logic [3:0] ACT_DRAIN_REJECTED  = 4'd2;
    localparam logic [3:0] ACT_FLUSH_DONE      = 4'd3;
    localparam logic [3:0] ACT_FLUSH_FAILED    = 4'd4;
    localparam logic [3:0] ACT_PORTS_DONE      = 4'd5;
    localparam logic [3:0] ACT_PORTS_FAILED    = 4'd6;
    localparam logic [3:0] ACT_RETAIN_DONE     = 4'd7;
    localparam logic [3:0] ACT_RETAIN_FAILED   = 4'd8;
    localparam logic [3:0] ACT_SLEEP_ENTERED   = 4'd9;
    localparam logic [3:0] ACT_SLEEP_FAILED    = 4'd10;
    localparam logic [3:0] ACT_WAKE_BOOT       = 4'd11;

    typedef struct packed {
        logic   ok;
        state_t dst;
    } move_t;

    typedef struct packed {
        state_t      prev_state;
        state_t      post_state;
        logic [3:0]  action;
        logic        accepted;
        logic [7:0]  status;
        logic [31:0] reason;
        logic [31:0] count;
    } res_t;

    // fixed transition table: legality and destination of an action
    function automatic move_t lookup_move(state_t src, logic [3:0] act);
        move_t m;
        m.ok  = 1'b0;
        m.dst = src;
        case (act)
            ACT_REQUEST_SLEEP:
            begin
                m.ok = (src == ST_ACTIVE);
                m.dst = ST_SLEEP_REQ;
            end
            ACT_DRAIN_DONE:
            begin
                m.ok = (src == ST_SLEEP_REQ);
                m.dst = ST_DRAINING;
            end
            ACT_DRAIN_REJECTED:
            begin
                m.ok = (src == ST_SLEEP_REQ) || (src == ST_DRAINING);
                m.dst = ST_REJECTED;
            end
            ACT_FLUSH_DONE:
            begin
                m.ok = (src == ST_DRAINING);
                m.dst = ST_LOGFLUSH;
            end
            ACT_FLUSH_FAILED:
            begin
                m.ok = (src == ST_DRAINING) || (src == ST_LOGFLUSH);
                m.dst = ST_FAILED;
            end
            ACT_PORTS_DONE:
            begin
                m.ok = (src == ST_LOGFLUSH);
                m.dst = ST_PORTS;
            end
            ACT_PORTS_FAILED:
            begin
                m.ok = (src == ST_LOGFLUSH) || (src == ST_PORTS);
                m.dst = ST_FAILED;
            end
            ACT_RETAIN_DONE:
            begin
                m.ok = (src == ST_PORTS);
                m.dst = ST_RETAINED;
            end
            ACT_RETAIN_FAILED:
            begin
                m.ok = (src == ST_PORTS);
                m.dst = ST_FAILED;
            end
            ACT_SLEEP_ENTERED:
            begin
                m.ok = (src == ST_RETAINED);
                m.dst = ST_ENTERING;
            end
            ACT_SLEEP_FAILED:
            begin
                m.ok = (src == ST_RETAINED) || (src == ST_ENTERING);
                m.dst = ST_FAILED;
            end
            ACT_WAKE_BOOT:
            begin
                m.ok = (src == ST_WAKEBOOT) || (src == ST_ENTERING) ||
                       (src == ST_FAILED) || (src == ST_REJECTED);
                m.dst = ST_ACTIVE;
            end
            default:
            begin
                m.ok  = 1'b0;
                m.dst = src;
            end
        endcase
        if (!m.ok)
        begin
            m.dst = src;
        end
        return m;
    endfunction

endpackage

>>> sv/dses_fsm.sv
// ----------------------------------------------------------------------------
// dses_fsm
// sleep entry state and transition counter, builds the report for one event
// ----------------------------------------------------------------------------
`include "deep_sleep_entry_sequencer_top_assert.svh"

module dses_fsm (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic [3:0]        action,
    input  logic [7:0]        status,
    input  logic [31:0]       reason,
    output dses_pkg::res_t    res
);
    import dses_pkg::*;

    state_t      state_reg;
    state_t      state_next;
    logic [31:0] count_reg;
    logic [31:0] count_next;
    move_t       move;

    // table lookup for the held event
    assign move = lookup_move(state_reg, action);

    // next state
    always_comb
    begin
        state_next = state_reg;
        if (advance)
        begin
            state_next = move.dst;
        end
    end

    // transition count, wraps at 32 bits
    always_comb
    begin
        count_next = count_reg;
        if (advance && move.ok)
        begin
            count_next = count_reg + 32'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACTIVE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // report for this event
    always_comb
    begin
        res.prev_state = state_reg;
        res.post_state = move.dst;
        res.action     = action;
        res.accepted   = move.ok;
        res.status     = move.ok ? status : 8'd0;
        res.reason     = reason;
        res.count      = count_next;
    end

    `DSES_ASSERT_NEXT(a_count_step, advance && move.ok,
        count_reg == 32'($past(count_reg) + 32'd1), "count did not step on transfer")
    `DSES_ASSERT_NEXT(a_reject_holds, advance && !move.ok,
        state_reg == $past(state_reg) && count_reg == $past(count_reg),
        "rejected event changed state or count")
    `DSES_ASSERT_NEXT(a_idle_holds, !advance,
        state_reg == $past(state_reg) && count_reg == $past(count_reg),
        "state moved without an event")

endmodule

>>> sv/dses_out_reg.sv
// ----------------------------------------------------------------------------
// dses_out_reg
// result register toward the master side
// ----------------------------------------------------------------------------
module dses_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  logic              take,
    input  dses_pkg::res_t    res_in,
    output logic              valid,
    output dses_pkg::res_t    res_out
);
    import dses_pkg::*;

    logic valid_reg;
    logic valid_next;
    res_t res_reg;

    // valid flag: set on load, cleared when the result is taken
    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

    assign valid   = valid_reg;
    assign res_out = res_reg;

endmodule

>>> sv/deep_sleep_entry_sequencer_top.sv
// ----------------------------------------------------------------------------
// deep_sleep_entry_sequencer_top
// path: an input transfer enters the input register, its result then the result register
// throughput: one event per cycle while the master side takes results, set by the input and result registers
// the state table lookup and counter update sit between those two registers
// reset: state to active, transition count to zero, both stages empty
// ----------------------------------------------------------------------------
module deep_sleep_entry_sequencer_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // action[3:0], input_status[11:4], reason[43:12]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata,  // prev_state[3:0], post_state[7:4],
                                       // action_echo[11:8], status_out[19:12],
                                       // reason_echo[51:20], count_out[83:52]
    output logic        m_axis_tuser   // accepted
);
    import dses_pkg::*;

    logic        in_valid_reg;
    logic        in_valid_next;
    logic [3:0]  action_reg;
    logic [7:0]  status_reg;
    logic [31:0] reason_reg;
    logic        advance;
    logic        s_xfer;
    res_t        res;
    res_t        res_out;

    // pipeline control
    assign advance       = in_valid_reg && (!m_axis_tvalid || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_xfer        = s_axis_tvalid && s_axis_tready;

    // input register
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_xfer)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_xfer)
        begin
            action_reg <= s_axis_tdata[3:0];
            status_reg <= s_axis_tdata[11:4];
            reason_reg <= s_axis_tdata[43:12];
        end
    end

    // state table and counter
    dses_fsm u_fsm (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .action  (action_reg),
        .status  (status_reg),
        .reason  (reason_reg),
        .res     (res)
    );

    // result register
    dses_out_reg u_out (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (advance),
        .take    (m_axis_tready),
        .res_in  (res),
        .valid   (m_axis_tvalid),
        .res_out (res_out)
    );

    // output packing
    assign m_axis_tdata = {4'd0, res_out.count, res_out.reason, res_out.status,
                           res_out.action, 4'(res_out.post_state),
                           4'(res_out.prev_state)};
    assign m_axis_tuser = res_out.accepted;

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb - deep sleep entry sequencer testbench
// drives sleep entry events into the stream slave port and predicts every
// report with its own copy of the transition table, state and move counter.
// results are compared field by field in arrival order. random idling on
// both sides, a long receiver hold-off and a full drain pause are included
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dses_pkg::*;

    localparam int LONG_HOLD = 300;

    // expected report store and state predictor
    class sleep_seq_scoreboard;
        state_t      cur_state;
        logic [31:0] move_count;
        res_t        pending[$];
        int          errors;
        int          n_checked;
        int          n_accepted;
        int          n_rejected;
        bit [9:0]    states_seen;

        function new();
            cur_state   = ST_ACTIVE;
            move_count  = 32'd0;
            errors      = 0;
            n_checked   = 0;
            n_accepted  = 0;
            n_rejected  = 0;
            states_seen = 10'b1;
        endfunction

        // destination of an action; no legal move keeps the state, so an
        // action is rejected exactly when the destination equals the source
        function state_t step_target(state_t src, logic [3:0] act);
            state_t dst;
            dst = src;
            case (src)
                ST_ACTIVE:
                begin
                    if (act == ACT_REQUEST_SLEEP)
                        dst = ST_SLEEP_REQ;
                end
                ST_SLEEP_REQ:
                begin
                    case (act)
                        ACT_DRAIN_DONE:     dst = ST_DRAINING;
                        ACT_DRAIN_REJECTED: dst = ST_REJECTED;
                        default:            dst = src;
                    endcase
                end
                ST_DRAINING:
                begin
                    case (act)
                        ACT_FLUSH_DONE:     dst = ST_LOGFLUSH;
                        ACT_DRAIN_REJECTED: dst = ST_REJECTED;
                        ACT_FLUSH_FAILED:   dst = ST_FAILED;
                        default:            dst = src;
                    endcase
                end
                ST_LOGFLUSH:
                begin
                    case (act)
                        ACT_PORTS_DONE:     dst = ST_PORTS;
                        ACT_FLUSH_FAILED:   dst = ST_FAILED;
                        ACT_PORTS_FAILED:   dst = ST_FAILED;
                        default:            dst = src;
                    endcase
                end
                ST_PORTS:
                begin
                    case (act)
                        ACT_RETAIN_DONE:    dst = ST_RETAINED;
                        ACT_PORTS_FAILED:   dst = ST_FAILED;
                        ACT_RETAIN_FAILED:  dst = ST_FAILED;
                        default:            dst = src;
                    endcase
                end
                ST_RETAINED:
                begin
                    case (act)
                        ACT_SLEEP_ENTERED:  dst = ST_ENTERING;
                        ACT_SLEEP_FAILED:   dst = ST_FAILED;
                        default:            dst = src;
                    endcase
                end
                ST_ENTERING:
                begin
                    case (act)
                        ACT_SLEEP_FAILED:   dst = ST_FAILED;
                        ACT_WAKE_BOOT:      dst = ST_ACTIVE;
                        default:            dst = src;
                    endcase
                end
                // wake boot, rejected and failed all only leave on wake boot
                default:
                begin
                    if (act == ACT_WAKE_BOOT)
                        dst = ST_ACTIVE;
                end
            endcase
            return dst;
        endfunction

        // an event transfer was accepted: advance the prediction
        function void note_event(logic [3:0] act, logic [7:0] stat, logic [31:0] rsn);
            res_t   r;
            state_t dst;
            dst          = step_target(cur_state, act);
            r.prev_state = cur_state;
            r.post_state = dst;
            r.action     = act;
            r.accepted   = (dst != cur_state);
            r.status     = r.accepted ? stat : 8'd0;
            r.reason     = rsn;
            if (r.accepted)
                move_count = move_count + 32'd1;
            r.count      = move_count;
            cur_state    = dst;
            states_seen[dst] = 1'b1;
            pending.push_back(r);
        endfunction

        task report_error(string msg);
            $display("ERROR @%0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report_error($sformatf("report %0d %s got 0x%0h expected 0x%0h",
                                       n_checked, name, got, want));
        endtask

        // a report transfer arrived: compare with the oldest expectation
        task check_result(logic [87:0] data, logic acc);
            res_t want;
            if (pending.size() == 0)
            begin
                report_error($sformatf("unexpected report, data 0x%0h", data));
            end
            else
            begin
                want = pending.pop_front();
                check_field("prev_state", 32'(data[3:0]), 32'(want.prev_state));
                check_field("post_state", 32'(data[7:4]), 32'(want.post_state));
                check_field("action_echo", 32'(data[11:8]), 32'(want.action));
                check_field("accepted", 32'(acc), 32'(want.accepted));
                check_field("status_out", 32'(data[19:12]), 32'(want.status));
                check_field("reason_echo", data[51:20], want.reason);
                check_field("count_out", data[83:52], want.count);
                if (want.accepted)
                    n_accepted++;
                else
                    n_rejected++;
                n_checked++;
            end
        endtask
    endclass

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata  = 48'd0;   // action[3:0], input_status[11:4], reason[43:12]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [87:0] m_axis_tdata;            // prev_state[3:0], post_state[7:4],
                                          // action_echo[11:8], status_out[19:12],
                                          // reason_echo[51:20], count_out[83:52]
    logic        m_axis_tuser;            // accepted

    bit rx_throttle  = 1'b1;
    bit hold_request = 1'b0;
    bit hold_done    = 1'b0;
    bit tx_throttle  = 1'b1;
    int stall_left   = 0;

    sleep_seq_scoreboard sb = new();

    deep_sleep_entry_sequencer_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 clk = ~clk;

    // receiver: random stall bursts, or one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_request && !hold_done)
        begin
            hold_done = 1'b1;
            stall_left = LONG_HOLD;
        end
        else if (stall_left == 0 && rx_throttle && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(1, 10);
        end
        if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    // report monitor
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);
    end

    // offer one event until its transfer, then maybe idle for a burst
    task automatic send_event(logic [3:0] act, logic [7:0] stat, logic [31:0] rsn);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, rsn, stat, act};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_event(act, stat, rsn);
        if (tx_throttle && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 10);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // mostly a legal next step of the sequence, sometimes any code at all
    task automatic send_random(bit well_formed);
        logic [3:0]  legal[$];
        logic [3:0]  act;
        logic [7:0]  stat;
        logic [31:0] rsn;
        for (int a = 0; a < 12; a++)
        begin
            if (sb.step_target(sb.cur_state, a[3:0]) != sb.cur_state)
                legal.push_back(a[3:0]);
        end
        if (well_formed)
            act = legal[$urandom_range(0, legal.size() - 1)];
        else
            act = 4'($urandom_range(0, 15));
        case ($urandom_range(0, 3))
            0:       stat = 8'h00;
            1:       stat = 8'hff;
            default: stat = 8'($urandom);
        endcase
        case ($urandom_range(0, 7))
            0:       rsn = 32'h0;
            1:       rsn = 32'hffff_ffff;
            default: rsn = $urandom;
        endcase
        send_event(act, stat, rsn);
    endtask

    task automatic run_random(int n);
        repeat (n) send_random($urandom_range(0, 4) != 0);
    endtask

    // stop offering and wait until every expected report has come back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    // main sequence
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: full entry walk, drain rejection and retention failure exits, undefined codes
        send_event(4'd15, 8'hff, 32'hffff_ffff);
        send_event(ACT_WAKE_BOOT, 8'h00, 32'h0);
        send_event(ACT_REQUEST_SLEEP, 8'h00, 32'h0);
        send_event(ACT_DRAIN_DONE, 8'hff, 32'hffff_ffff);
        send_event(ACT_FLUSH_DONE, 8'h00, $urandom);
        send_event(ACT_PORTS_DONE, 8'hff, $urandom);
        send_event(ACT_RETAIN_DONE, 8'h00, 32'hffff_ffff);
        send_event(ACT_SLEEP_ENTERED, 8'hff, 32'h0);
        send_event(ACT_WAKE_BOOT, 8'h5a, $urandom);
        send_event(ACT_REQUEST_SLEEP, 8'ha5, $urandom);
        send_event(ACT_DRAIN_REJECTED, 8'hff, $urandom);
        send_event(4'd12, 8'hff, 32'hffff_ffff);
        send_event(ACT_WAKE_BOOT, 8'h01, $urandom);
        send_event(ACT_REQUEST_SLEEP, 8'h80, $urandom);
        send_event(ACT_DRAIN_DONE, 8'h00, $urandom);
        send_event(ACT_DRAIN_REJECTED, 8'h7f, $urandom);
        send_event(ACT_WAKE_BOOT, 8'h00, $urandom);
        send_event(ACT_REQUEST_SLEEP, 8'h00, $urandom);
        send_event(ACT_DRAIN_DONE, 8'h00, $urandom);
        send_event(ACT_FLUSH_DONE, 8'h00, $urandom);
        send_event(ACT_PORTS_DONE, 8'h00, $urandom);
        send_event(ACT_RETAIN_FAILED, 8'hee, $urandom);
        send_event(4'd13, 8'h33, $urandom);
        send_event(ACT_WAKE_BOOT, 8'hff, 32'hffff_ffff);

        // random with idling on both sides
        run_random(500);

        // long receiver hold-off while the sender keeps offering
        tx_throttle = 1'b0;
        hold_request <= 1'b1;
        run_random(60);
        tx_throttle = 1'b1;

        // sender pause until everything is back
        wait_drained();

        run_random(500);

        // closing stretch with no idling
        rx_throttle <= 1'b0;
        tx_throttle = 1'b0;
        run_random(260);

        wait_drained();
        repeat (10) @(posedge clk);

        $display("checked %0d reports: %0d accepted moves, %0d rejected actions",
                 sb.n_checked, sb.n_accepted, sb.n_rejected);
        $display("states reached (bit per state, active lowest): %b", sb.states_seen);
        if (sb.errors == 0)
            $display("deep_sleep_entry_sequencer_top test passed");
        else
            $display("deep_sleep_entry_sequencer_top test failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("timeout: %0d reports still expected", sb.pending.size());
        $display("deep_sleep_entry_sequencer_top test failed");
        $finish;
    end

endmodule
